FILE: rtl/lpr_pkg.sv
`default_nettype none

package lpr_pkg;

	localparam logic [13:0] MAX_STRING_LEN     = 14'd4096;
	localparam logic [6:0]  MAX_RESOURCE_PAIRS = 7'd100;
	localparam logic [6:0]  ALL_FIXED          = 7'h7F;
	localparam logic [2:0]  WIRE_LEN           = 3'd2;

	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_FIXED = 2'd1;
	localparam logic [1:0] KIND_KEY   = 2'd2;
	localparam logic [1:0] KIND_VALUE = 2'd3;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_WIRE_TYPE  = 4'd1;
	localparam logic [3:0] ST_VARINT     = 4'd2;
	localparam logic [3:0] ST_TOO_LONG   = 4'd3;
	localparam logic [3:0] ST_SUB_OVER   = 4'd4;
	localparam logic [3:0] ST_TRUNCATED  = 4'd5;
	localparam logic [3:0] ST_SUB_FIELD  = 4'd6;
	localparam logic [3:0] ST_DUPLICATE  = 4'd7;
	localparam logic [3:0] ST_UNKNOWN    = 4'd8;
	localparam logic [3:0] ST_TOO_MANY   = 4'd9;
	localparam logic [3:0] ST_MISSING    = 4'd10;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} beat_t;

endpackage

`default_nettype wire

FILE: rtl/lpr_in_stage.sv
`default_nettype none

module lpr_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire lpr_pkg::beat_t in_beat,
	input  wire logic          take,
	output logic               valid_s1,
	output lpr_pkg::beat_t     beat_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lpr_decoder.sv
`default_nettype none

module lpr_decoder (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s1,
	input  wire lpr_pkg::beat_t beat_s1,
	output logic                take,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          data_byte,
	output logic                data_valid,
	output logic [1:0]          byte_kind,
	output logic [3:0]          field_id,
	output logic [6:0]          pair_index,
	output logic                string_end,
	output logic                payload_done,
	output logic [3:0]          status
);

	typedef enum logic [3:0] {
		PH_TAG, PH_LEN1, PH_LEN2, PH_STR, PH_RLEN1, PH_RLEN2, PH_KTAG, PH_KLEN1,
		PH_KLEN2, PH_KSTR, PH_VTAG, PH_VLEN1, PH_VLEN2, PH_VSTR, PH_SKIP, PH_ERR
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [6:0]  vlow_q, vlow_d;
	logic [12:0] sleft_q, sleft_d;
	logic [13:0] subl_q, subl_d;
	logic [3:0]  cur_q, cur_d;
	logic [6:0]  seen_q, seen_d;
	logic [6:0]  pairs_q, pairs_d;
	logic [3:0]  ferr_q, ferr_d;

	logic        o_valid, o_end, done;
	logic [1:0]  o_kind;
	logic [3:0]  o_field, err, stat;
	logic [6:0]  o_pair;
	logic [7:0]  b;
	logic [4:0]  tag_field;
	logic        wire_ok, is_key, do_fixed, do_sub, do_finish, do_after;
	logic [13:0] rem, len_v, len1_v, len2_v;
	logic [3:0]  fdiff;
	logic [2:0]  fidx;

	assign take = valid_s1 && (!out_valid || out_ready);

	always_comb begin
		b         = beat_s1.byte_value;
		tag_field = b[7:3];
		wire_ok   = (b[2:0] == lpr_pkg::WIRE_LEN);
		len1_v    = {7'd0, b[6:0]};
		len2_v    = {b[6:0], vlow_q};
		fdiff     = cur_q - 4'd2;
		fidx      = fdiff[2:0];

		phase_d = phase_q;
		vlow_d  = vlow_q;
		sleft_d = sleft_q;
		subl_d  = subl_q;
		cur_d   = cur_q;
		seen_d  = seen_q;
		pairs_d = pairs_q;
		ferr_d  = ferr_q;

		o_valid   = 1'b0;
		o_end     = 1'b0;
		o_kind    = lpr_pkg::KIND_FRAME;
		o_field   = 4'd0;
		o_pair    = 7'd0;
		err       = lpr_pkg::ST_OK;
		done      = 1'b0;
		stat      = lpr_pkg::ST_OK;
		is_key    = 1'b0;
		do_fixed  = 1'b0;
		do_sub    = 1'b0;
		do_finish = 1'b0;
		do_after  = 1'b0;
		len_v     = len1_v;
		rem       = 14'd0;

		if (phase_q inside {[PH_KTAG:PH_SKIP]}) begin
			if (subl_q != 14'd0) begin
				subl_d = subl_q - 14'd1;
			end
			rem = subl_d;
		end

		case (phase_q)
			PH_TAG: begin
				if (!wire_ok) begin
					err = lpr_pkg::ST_WIRE_TYPE;
				end else if (tag_field == 5'd1) begin
					if (pairs_q >= lpr_pkg::MAX_RESOURCE_PAIRS) begin
						err = lpr_pkg::ST_TOO_MANY;
					end else begin
						phase_d = PH_RLEN1;
					end
				end else if (tag_field inside {[5'd2:5'd9]}) begin
					cur_d   = tag_field[3:0];
					phase_d = PH_LEN1;
				end else begin
					err = lpr_pkg::ST_UNKNOWN;
				end
			end
			PH_LEN1: begin
				if (!b[7]) begin
					do_fixed = 1'b1;
				end else begin
					vlow_d  = b[6:0];
					phase_d = PH_LEN2;
				end
			end
			PH_RLEN1: begin
				if (!b[7]) begin
					if (b == 8'd0) begin
						err = lpr_pkg::ST_SUB_OVER;
					end else begin
						subl_d  = len1_v;
						phase_d = PH_KTAG;
					end
				end else begin
					vlow_d  = b[6:0];
					phase_d = PH_RLEN2;
				end
			end
			PH_LEN2: begin
				if (b[7]) begin
					err = lpr_pkg::ST_VARINT;
				end else begin
					len_v    = len2_v;
					do_fixed = 1'b1;
				end
			end
			PH_RLEN2: begin
				if (b[7]) begin
					err = lpr_pkg::ST_VARINT;
				end else begin
					subl_d  = len2_v;
					phase_d = PH_KTAG;
				end
			end
			PH_STR: begin
				o_kind  = lpr_pkg::KIND_FIXED;
				o_field = cur_q;
				o_valid = 1'b1;
				sleft_d = sleft_q - 13'd1;
				if (sleft_d == 13'd0) begin
					o_end     = 1'b1;
					do_finish = 1'b1;
				end
			end
			PH_KTAG, PH_VTAG: begin
				if (!wire_ok) begin
					err = lpr_pkg::ST_WIRE_TYPE;
				end else if (tag_field != ((phase_q == PH_KTAG) ? 5'd1 : 5'd2)) begin
					err = lpr_pkg::ST_SUB_FIELD;
				end else if (rem == 14'd0) begin
					err = lpr_pkg::ST_SUB_OVER;
				end else begin
					phase_d = (phase_q == PH_KTAG) ? PH_KLEN1 : PH_VLEN1;
				end
			end
			PH_KLEN1, PH_VLEN1: begin
				is_key = (phase_q == PH_KLEN1);
				if (!b[7]) begin
					do_sub = 1'b1;
				end else if (rem == 14'd0) begin
					err = lpr_pkg::ST_SUB_OVER;
				end else begin
					vlow_d  = b[6:0];
					phase_d = is_key ? PH_KLEN2 : PH_VLEN2;
				end
			end
			PH_KLEN2, PH_VLEN2: begin
				is_key = (phase_q == PH_KLEN2);
				if (b[7]) begin
					err = lpr_pkg::ST_VARINT;
				end else begin
					len_v  = len2_v;
					do_sub = 1'b1;
				end
			end
			PH_KSTR, PH_VSTR: begin
				is_key  = (phase_q == PH_KSTR);
				o_kind  = is_key ? lpr_pkg::KIND_KEY : lpr_pkg::KIND_VALUE;
				o_field = 4'd1;
				o_pair  = pairs_q;
				o_valid = 1'b1;
				sleft_d = sleft_q - 13'd1;
				if (sleft_d == 13'd0) begin
					o_end    = 1'b1;
					do_after = 1'b1;
				end
			end
			PH_SKIP: begin
				if (rem == 14'd0) begin
					phase_d = PH_TAG;
				end
			end
			default: begin
			end
		endcase

		if (do_fixed) begin
			if (len_v > lpr_pkg::MAX_STRING_LEN) begin
				err = lpr_pkg::ST_TOO_LONG;
			end else if (len_v == 14'd0) begin
				o_end     = 1'b1;
				o_kind    = lpr_pkg::KIND_FIXED;
				o_field   = cur_q;
				do_finish = 1'b1;
			end else begin
				sleft_d = len_v[12:0];
				phase_d = PH_STR;
			end
		end

		if (do_sub) begin
			if (len_v > lpr_pkg::MAX_STRING_LEN) begin
				err = lpr_pkg::ST_TOO_LONG;
			end else if (len_v > rem) begin
				err = lpr_pkg::ST_SUB_OVER;
			end else if (len_v == 14'd0) begin
				o_end    = 1'b1;
				o_kind   = is_key ? lpr_pkg::KIND_KEY : lpr_pkg::KIND_VALUE;
				o_field  = 4'd1;
				o_pair   = pairs_q;
				do_after = 1'b1;
			end else begin
				sleft_d = len_v[12:0];
				phase_d = is_key ? PH_KSTR : PH_VSTR;
			end
		end

		if (do_finish) begin
			phase_d = PH_TAG;
			if (cur_q < 4'd2 || cur_q > 4'd8) begin
				err = lpr_pkg::ST_DUPLICATE;
			end else if (seen_q[fidx]) begin
				err = lpr_pkg::ST_DUPLICATE;
			end else begin
				seen_d[fidx] = 1'b1;
			end
		end

		if (do_after) begin
			if (is_key) begin
				if (rem == 14'd0) begin
					err = lpr_pkg::ST_SUB_OVER;
				end else begin
					phase_d = PH_VTAG;
				end
			end else begin
				pairs_d = pairs_q + 7'd1;
				phase_d = (rem == 14'd0) ? PH_TAG : PH_SKIP;
			end
		end

		if (err != lpr_pkg::ST_OK && ferr_q == lpr_pkg::ST_OK) begin
			ferr_d  = err;
			phase_d = PH_ERR;
		end

		if (beat_s1.last_byte) begin
			done = 1'b1;
			stat = ferr_d;
			if (stat == lpr_pkg::ST_OK && phase_d != PH_TAG) begin
				stat = lpr_pkg::ST_TRUNCATED;
			end
			if (stat == lpr_pkg::ST_OK && seen_d != lpr_pkg::ALL_FIXED) begin
				stat = lpr_pkg::ST_MISSING;
			end
			phase_d = PH_TAG;
			vlow_d  = 7'd0;
			sleft_d = 13'd0;
			subl_d  = 14'd0;
			cur_d   = 4'd0;
			seen_d  = 7'd0;
			pairs_d = 7'd0;
			ferr_d  = lpr_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG;
			vlow_q    <= 7'd0;
			sleft_q   <= 13'd0;
			subl_q    <= 14'd0;
			cur_q     <= 4'd0;
			seen_q    <= 7'd0;
			pairs_q   <= 7'd0;
			ferr_q    <= lpr_pkg::ST_OK;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				phase_q      <= phase_d;
				vlow_q       <= vlow_d;
				sleft_q      <= sleft_d;
				subl_q       <= subl_d;
				cur_q        <= cur_d;
				seen_q       <= seen_d;
				pairs_q      <= pairs_d;
				ferr_q       <= ferr_d;
				out_valid    <= 1'b1;
				data_byte    <= b;
				data_valid   <= o_valid;
				byte_kind    <= o_kind;
				field_id     <= o_field;
				pair_index   <= o_pair;
				string_end   <= o_end;
				payload_done <= done;
				status       <= stat;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && beat_s1.last_byte) |=> (phase_q == PH_TAG && seen_q == 7'd0
			&& pairs_q == 7'd0 && ferr_q == lpr_pkg::ST_OK))
		else $error("payload state not cleared after last byte");
	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(ferr_q != lpr_pkg::ST_OK) == (phase_q == PH_ERR))
		else $error("sticky error and error phase disagree");
	a_valid_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && data_valid) |-> (byte_kind != lpr_pkg::KIND_FRAME && !payload_done
			|| byte_kind != lpr_pkg::KIND_FRAME))
		else $error("string content beat tagged as framing");
	a_pair_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pairs_q <= lpr_pkg::MAX_RESOURCE_PAIRS)
		else $error("pair count beyond limit");
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !beat_s1.last_byte) |=> (status == lpr_pkg::ST_OK && !payload_done))
		else $error("status reported off the last byte");
`endif

endmodule

`default_nettype wire

FILE: rtl/limited_protobuf_record_parser_top.sv
`default_nettype none

// channel | handshake            | payload
// in      | in_valid / in_ready  | byte_value, last_byte
// out     | out_valid / out_ready| data_byte, data_valid, byte_kind, field_id,
//         |                      | pair_index, string_end, payload_done, status
//
// One byte per cycle sustained while out_ready is held high; an input beat passes through
// the input register, then the decode into the result register.
// The parse state updates when a byte moves from the input register to the result register.
// Reset clears the parse state and both valid flags; no clearing pass is needed.
// A stalled output holds its beat; one more input beat is absorbed in the input register.

module limited_protobuf_record_parser_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_value,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      data_byte,
	output logic            data_valid,
	output logic [1:0]      byte_kind,
	output logic [3:0]      field_id,
	output logic [6:0]      pair_index,
	output logic            string_end,
	output logic            payload_done,
	output logic [3:0]      status
);

	lpr_pkg::beat_t in_beat, beat_s1;
	logic           valid_s1, take;

	assign in_beat.byte_value = byte_value;
	assign in_beat.last_byte  = last_byte;

	lpr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.take     (take),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	lpr_decoder u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.beat_s1      (beat_s1),
		.take         (take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.data_valid   (data_valid),
		.byte_kind    (byte_kind),
		.field_id     (field_id),
		.pair_index   (pair_index),
		.string_end   (string_end),
		.payload_done (payload_done),
		.status       (status)
	);

endmodule

`default_nettype wire

FILE: sim/lpr_byte_checker.sv
`timescale 1ns / 1ps

module lpr_byte_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] byte_value,
	input  wire logic       last_byte,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       data_valid,
	input  wire logic [1:0] byte_kind,
	input  wire logic [3:0] field_id,
	input  wire logic [6:0] pair_index,
	input  wire logic       string_end,
	input  wire logic       payload_done,
	input  wire logic [3:0] status,
	output int              fails,
	output int              waiting,
	output int              beats_seen,
	output int              payloads_seen,
	output int              clean_seen
);

	typedef enum logic [3:0] {
		AT_TAG, AT_LEN1, AT_LEN2, IN_STR, AT_RLEN1, AT_RLEN2, AT_KTAG, AT_KLEN1,
		AT_KLEN2, IN_KEY, AT_VTAG, AT_VLEN1, AT_VLEN2, IN_VAL, IN_SKIP, HALTED
	} phase_t;

	typedef struct packed {
		logic [7:0] dbyte;
		logic       dvalid;
		logic [1:0] kind;
		logic [3:0] field;
		logic [6:0] pair;
		logic       strend;
		logic       done;
		logic [3:0] status;
	} byte_tag_t;

	phase_t      phase;
	logic [6:0]  lo7;
	logic [12:0] str_left;
	logic [13:0] sub_left;
	logic [3:0]  cur_field;
	logic [6:0]  seen;
	logic [6:0]  pairs;
	logic [3:0]  first_err;

	logic        o_valid;
	logic [1:0]  o_kind;
	logic [3:0]  o_field;
	logic [6:0]  o_pair;
	logic        o_end;
	logic [3:0]  o_err;

	byte_tag_t   tags_due[$];
	byte_tag_t   due;

	function automatic void reset_parse();
		phase = AT_TAG;
		lo7 = '0;
		str_left = '0;
		sub_left = '0;
		cur_field = '0;
		seen = '0;
		pairs = '0;
		first_err = lpr_pkg::ST_OK;
	endfunction

	function automatic void close_fixed();
		phase = AT_TAG;
		if (cur_field < 4'd2 || cur_field > 4'd8) o_err = lpr_pkg::ST_DUPLICATE;
		else if (seen[cur_field - 4'd2]) o_err = lpr_pkg::ST_DUPLICATE;
		else seen[cur_field - 4'd2] = 1'b1;
	endfunction

	function automatic void take_fixed_len(input logic [13:0] len);
		if (len > lpr_pkg::MAX_STRING_LEN) begin
			o_err = lpr_pkg::ST_TOO_LONG;
		end else if (len == 14'd0) begin
			o_end = 1'b1;
			o_kind = lpr_pkg::KIND_FIXED;
			o_field = cur_field;
			close_fixed();
		end else begin
			str_left = len[12:0];
			phase = IN_STR;
		end
	endfunction

	function automatic void close_sub(input logic is_key, input logic [13:0] rem);
		if (is_key) begin
			if (rem == 14'd0) o_err = lpr_pkg::ST_SUB_OVER;
			else phase = AT_VTAG;
		end else begin
			pairs = pairs + 7'd1;
			phase = (rem == 14'd0) ? AT_TAG : IN_SKIP;
		end
	endfunction

	function automatic void take_sub_len(input logic [13:0] len, input logic is_key,
			input logic [13:0] rem);
		if (len > lpr_pkg::MAX_STRING_LEN) begin
			o_err = lpr_pkg::ST_TOO_LONG;
		end else if (len > rem) begin
			o_err = lpr_pkg::ST_SUB_OVER;
		end else if (len == 14'd0) begin
			o_end = 1'b1;
			o_kind = is_key ? lpr_pkg::KIND_KEY : lpr_pkg::KIND_VALUE;
			o_field = 4'd1;
			o_pair = pairs;
			close_sub(is_key, rem);
		end else begin
			str_left = len[12:0];
			phase = is_key ? IN_KEY : IN_VAL;
		end
	endfunction

	function automatic void check_sub_tag(input logic [7:0] b, input logic [4:0] want,
			input logic [13:0] rem, input phase_t nxt);
		if (b[2:0] != lpr_pkg::WIRE_LEN) o_err = lpr_pkg::ST_WIRE_TYPE;
		else if (b[7:3] != want) o_err = lpr_pkg::ST_SUB_FIELD;
		else if (rem == 14'd0) o_err = lpr_pkg::ST_SUB_OVER;
		else phase = nxt;
	endfunction

	function automatic byte_tag_t decode_byte(input logic [7:0] b, input logic fin);
		byte_tag_t  t;
		logic [13:0] rem;
		logic        is_key;
		rem = '0;
		o_valid = 1'b0;
		o_kind = lpr_pkg::KIND_FRAME;
		o_field = '0;
		o_pair = '0;
		o_end = 1'b0;
		o_err = lpr_pkg::ST_OK;
		if (phase >= AT_KTAG && phase <= IN_SKIP) begin
			if (sub_left != 14'd0) sub_left = sub_left - 14'd1;
			rem = sub_left;
		end
		case (phase)
			AT_TAG: begin
				if (b[2:0] != lpr_pkg::WIRE_LEN) begin
					o_err = lpr_pkg::ST_WIRE_TYPE;
				end else if (b[7:3] == 5'd1) begin
					if (pairs >= lpr_pkg::MAX_RESOURCE_PAIRS) o_err = lpr_pkg::ST_TOO_MANY;
					else phase = AT_RLEN1;
				end else if (b[7:3] >= 5'd2 && b[7:3] <= 5'd9) begin
					cur_field = b[6:3];
					phase = AT_LEN1;
				end else begin
					o_err = lpr_pkg::ST_UNKNOWN;
				end
			end
			AT_LEN1: begin
				if (!b[7]) take_fixed_len({7'd0, b[6:0]});
				else begin
					lo7 = b[6:0];
					phase = AT_LEN2;
				end
			end
			AT_RLEN1: begin
				if (b[7]) begin
					lo7 = b[6:0];
					phase = AT_RLEN2;
				end else if (b == 8'd0) begin
					o_err = lpr_pkg::ST_SUB_OVER;
				end else begin
					sub_left = {7'd0, b[6:0]};
					phase = AT_KTAG;
				end
			end
			AT_LEN2: begin
				if (b[7]) o_err = lpr_pkg::ST_VARINT;
				else take_fixed_len({b[6:0], lo7});
			end
			AT_RLEN2: begin
				if (b[7]) o_err = lpr_pkg::ST_VARINT;
				else begin
					sub_left = {b[6:0], lo7};
					phase = AT_KTAG;
				end
			end
			IN_STR: begin
				o_kind = lpr_pkg::KIND_FIXED;
				o_field = cur_field;
				o_valid = 1'b1;
				str_left = str_left - 13'd1;
				if (str_left == 13'd0) begin
					o_end = 1'b1;
					close_fixed();
				end
			end
			AT_KTAG: check_sub_tag(b, 5'd1, rem, AT_KLEN1);
			AT_VTAG: check_sub_tag(b, 5'd2, rem, AT_VLEN1);
			AT_KLEN1, AT_VLEN1: begin
				if (!b[7]) begin
					take_sub_len({7'd0, b[6:0]}, phase == AT_KLEN1, rem);
				end else if (rem == 14'd0) begin
					o_err = lpr_pkg::ST_SUB_OVER;
				end else begin
					lo7 = b[6:0];
					phase = (phase == AT_KLEN1) ? AT_KLEN2 : AT_VLEN2;
				end
			end
			AT_KLEN2, AT_VLEN2: begin
				if (b[7]) o_err = lpr_pkg::ST_VARINT;
				else take_sub_len({b[6:0], lo7}, phase == AT_KLEN2, rem);
			end
			IN_KEY, IN_VAL: begin
				is_key = (phase == IN_KEY);
				o_kind = is_key ? lpr_pkg::KIND_KEY : lpr_pkg::KIND_VALUE;
				o_field = 4'd1;
				o_pair = pairs;
				o_valid = 1'b1;
				str_left = str_left - 13'd1;
				if (str_left == 13'd0) begin
					o_end = 1'b1;
					close_sub(is_key, rem);
				end
			end
			IN_SKIP: begin
				if (rem == 14'd0) phase = AT_TAG;
			end
			default: ;
		endcase
		if (o_err != lpr_pkg::ST_OK && first_err == lpr_pkg::ST_OK) begin
			first_err = o_err;
			phase = HALTED;
		end
		t.dbyte = b;
		t.dvalid = o_valid;
		t.kind = o_kind;
		t.field = o_field;
		t.pair = o_pair;
		t.strend = o_end;
		t.done = fin;
		t.status = lpr_pkg::ST_OK;
		if (fin) begin
			if (first_err == lpr_pkg::ST_OK && phase != AT_TAG)
				first_err = lpr_pkg::ST_TRUNCATED;
			if (first_err == lpr_pkg::ST_OK && seen != lpr_pkg::ALL_FIXED)
				first_err = lpr_pkg::ST_MISSING;
			t.status = first_err;
			reset_parse();
		end
		return t;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_parse();
			tags_due.delete();
			fails = 0;
			beats_seen = 0;
			payloads_seen = 0;
			clean_seen = 0;
			waiting <= 0;
		end else begin
			if (in_valid && in_ready) tags_due.push_back(decode_byte(byte_value, last_byte));
			if (out_valid && out_ready) begin
				beats_seen++;
				if (tags_due.size() == 0) begin
					fails++;
					$error("result beat with no byte pending");
				end else begin
					due = tags_due.pop_front();
					check_field("data_byte", due.dbyte, data_byte);
					check_field("data_valid", due.dvalid, data_valid);
					check_field("byte_kind", due.kind, byte_kind);
					check_field("field_id", due.field, field_id);
					check_field("pair_index", due.pair, pair_index);
					check_field("string_end", due.strend, string_end);
					check_field("payload_done", due.done, payload_done);
					check_field("status", due.status, status);
					if (due.done) begin
						payloads_seen++;
						if (due.status == lpr_pkg::ST_OK) clean_seen++;
					end
				end
			end
			waiting <= tags_due.size();
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam logic [7:0] RES_TAG = 8'h0A;
	localparam logic [7:0] KEY_TAG = 8'h0A;
	localparam logic [7:0] VAL_TAG = 8'h12;

	typedef enum int {
		FL_NONE, FL_FIELD9, FL_DUP, FL_OMIT, FL_UNKNOWN, FL_WIRE, FL_TOO_LONG, FL_VARINT,
		FL_EMPTY_SUB, FL_SUB_LEN, FL_SUB_TAG, FL_KEY_ONLY, FL_COUNT
	} flaw_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] byte_value = 8'd0;
	logic       last_byte = 1'b0;
	logic       out_ready = 1'b0;

	wire        in_ready;
	wire        out_valid;
	wire [7:0]  data_byte;
	wire        data_valid;
	wire [1:0]  byte_kind;
	wire [3:0]  field_id;
	wire [6:0]  pair_index;
	wire        string_end;
	wire        payload_done;
	wire [3:0]  status;

	wire [31:0] fails;
	wire [31:0] waiting;
	wire [31:0] beats_seen;
	wire [31:0] payloads_seen;
	wire [31:0] clean_seen;

	logic [7:0] pl[$];
	bit         steady;
	int         sent_bytes = 0;

	limited_protobuf_record_parser_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_value(byte_value), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_byte(data_byte), .data_valid(data_valid), .byte_kind(byte_kind),
		.field_id(field_id), .pair_index(pair_index), .string_end(string_end),
		.payload_done(payload_done), .status(status)
	);

	lpr_byte_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_value(byte_value), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_byte(data_byte), .data_valid(data_valid), .byte_kind(byte_kind),
		.field_id(field_id), .pair_index(pair_index), .string_end(string_end),
		.payload_done(payload_done), .status(status),
		.fails(fails), .waiting(waiting), .beats_seen(beats_seen),
		.payloads_seen(payloads_seen), .clean_seen(clean_seen)
	);

	always #10 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int str_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 16);
		return $urandom_range(128, 160);
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic fin);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		last_byte <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic ship();
		if (pl.size() == 0) pl.push_back(8'($urandom));
		steady = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < pl.size(); i++) send_beat(pl[i], i == pl.size() - 1);
		sent_bytes += pl.size();
		pl.delete();
	endtask

	// short values take the padded two-byte form now and then
	task automatic put_varint(input int v);
		if (v < 128 && $urandom_range(0, 15) != 0) begin
			pl.push_back(v[7:0]);
		end else begin
			pl.push_back({1'b1, v[6:0]});
			pl.push_back({1'b0, v[13:7]});
		end
	endtask

	task automatic put_fixed(input int f, input int len);
		pl.push_back({f[4:0], lpr_pkg::WIRE_LEN});
		put_varint(len);
		repeat (len) pl.push_back(8'($urandom));
	endtask

	task automatic put_resource(input logic [7:0] ktag, input int adj);
		logic [7:0] body[$];
		int mark, klen, vlen, n;
		mark = pl.size();
		klen = str_len();
		vlen = str_len();
		pl.push_back(ktag);
		put_varint(klen);
		repeat (klen) pl.push_back(8'($urandom));
		pl.push_back(VAL_TAG);
		put_varint(vlen);
		repeat (vlen) pl.push_back(8'($urandom));
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) pl.push_back(8'($urandom));
		while (pl.size() > mark) body.push_front(pl.pop_back());
		n = body.size() + adj;
		if (n < 1) n = 1;
		pl.push_back(RES_TAG);
		put_varint(n);
		pl = {pl, body};
	endtask

	task automatic put_flaw(input flaw_t flaw);
		int f, w, d, n;
		case (flaw)
			FL_FIELD9: put_fixed(9, str_len());
			FL_DUP: put_fixed($urandom_range(2, 8), str_len());
			FL_UNKNOWN: begin
				f = $urandom_range(0, 22);
				if (f > 0) f += 9;
				put_fixed(f, str_len());
			end
			FL_WIRE: begin
				w = $urandom_range(0, 6);
				if (w >= 2) w++;
				pl.push_back({5'($urandom), 3'(w)});
			end
			FL_TOO_LONG: begin
				if ($urandom_range(0, 1)) begin
					pl.push_back({5'($urandom_range(2, 9)), lpr_pkg::WIRE_LEN});
					put_varint($urandom_range(4097, 16383));
				end else begin
					pl.push_back(RES_TAG);
					put_varint(16383);
					pl.push_back(KEY_TAG);
					put_varint($urandom_range(4097, 16383));
				end
			end
			FL_VARINT: begin
				pl.push_back($urandom_range(0, 1) ? RES_TAG
					: {5'($urandom_range(2, 8)), lpr_pkg::WIRE_LEN});
				pl.push_back(8'h80 | 8'($urandom));
				pl.push_back(8'h80 | 8'($urandom));
			end
			FL_EMPTY_SUB: begin
				pl.push_back(RES_TAG);
				pl.push_back(8'h00);
			end
			FL_SUB_LEN: begin
				d = $urandom_range(1, 3);
				put_resource(KEY_TAG, $urandom_range(0, 1) ? -d : d);
			end
			FL_SUB_TAG: put_resource($urandom_range(0, 1) ? VAL_TAG : 8'($urandom), 0);
			FL_KEY_ONLY: begin
				// submessage ends right after its key
				n = $urandom_range(0, 20);
				pl.push_back(RES_TAG);
				pl.push_back(8'(n + 2));
				pl.push_back(KEY_TAG);
				pl.push_back(8'(n));
				repeat (n) pl.push_back(8'($urandom));
			end
			default: ;
		endcase
	endtask

	task automatic compose(input flaw_t flaw, input int slot, input int nres);
		int order[7];
		int j, t, placed;
		for (int i = 0; i < 7; i++) order[i] = i + 2;
		for (int i = 6; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		placed = 0;
		for (int i = 0; i < 7; i++) begin
			while (placed < nres && $urandom_range(0, 2) == 0) begin
				put_resource(KEY_TAG, 0);
				placed++;
			end
			if (i == slot) put_flaw(flaw);
			if (!(i == slot && flaw == FL_OMIT)) put_fixed(order[i], str_len());
		end
		while (placed < nres) begin
			put_resource(KEY_TAG, 0);
			placed++;
		end
	endtask

	task automatic cut_short();
		pl = pl[0:$urandom_range(1, pl.size() - 1) - 1];
	endtask

	initial begin
		int n;
		while (!arst_n) @(posedge clk);
		forever begin
			n = idle_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 12))
				@(posedge clk);
		end
	end

	initial begin
		#10_000_000;
		$display("limited_protobuf_record_parser_top verification failed");
		$finish;
	end

	initial begin
		int r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every fixed field empty, one empty pair
		for (int f = 2; f <= 8; f++) begin
			pl.push_back({5'(f), lpr_pkg::WIRE_LEN});
			pl.push_back(8'h00);
		end
		pl = {pl, RES_TAG, 8'd4, KEY_TAG, 8'h00, VAL_TAG, 8'h00};
		ship();

		// longest legal length cut short, one past the limit, largest two-byte length
		pl = {8'h12, 8'h80, 8'h20, 8'h41, 8'h42};
		ship();
		pl = {8'h12, 8'h81, 8'h20};
		ship();
		pl = {8'h1A, 8'hFF, 8'h7F};
		ship();

		// pair table filled with empty pairs, then one pair too many
		for (int f = 2; f <= 8; f++) begin
			pl.push_back({5'(f), lpr_pkg::WIRE_LEN});
			pl.push_back(8'h00);
		end
		repeat (int'(lpr_pkg::MAX_RESOURCE_PAIRS) + 1)
			pl = {pl, RES_TAG, 8'd4, KEY_TAG, 8'h00, VAL_TAG, 8'h00};
		ship();

		for (int k = FL_NONE; k < FL_COUNT; k++) begin
			compose(flaw_t'(k), $urandom_range(0, 6), $urandom_range(0, 1));
			ship();
		end

		compose(FL_NONE, 0, 1);
		cut_short();
		ship();

		while (sent_bytes < 1700) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				repeat ($urandom_range(1, 12)) pl.push_back(8'($urandom));
			end else if (r < 62) begin
				compose(FL_NONE, 0, $urandom_range(0, 3));
			end else if (r < 90) begin
				compose(flaw_t'($urandom_range(1, FL_COUNT - 1)), $urandom_range(0, 6),
					$urandom_range(0, 3));
			end else begin
				compose(FL_NONE, 0, $urandom_range(0, 3));
				if (r < 95) pl[$urandom_range(0, pl.size() - 1)] = 8'($urandom);
				else cut_short();
			end
			ship();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d bytes checked across %0d payloads, %0d of them parsed clean",
			beats_seen, payloads_seen, clean_seen);
		$display("covered every record flaw kind, the string length limit and the pair limit");
		if (fails == 0) begin
			$display("limited_protobuf_record_parser_top verification clean");
		end else begin
			$display("limited_protobuf_record_parser_top verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lpr_pkg.sv
rtl/lpr_in_stage.sv
rtl/lpr_decoder.sv
rtl/limited_protobuf_record_parser_top.sv
sim/lpr_byte_checker.sv
sim/tb.sv
